[rtl/brle_pkg.sv]
package brle_pkg;

  // Byte and count widths of the encoder
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 6;

  // Command codes passed from the front to the back
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_FLUSH  = 2'd1;
  localparam logic [1:0] OP_REPEAT = 2'd2;

  // Number of command slots one input transaction can produce
  localparam int SLOTS = 4;

  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  len;
    logic              step_last;
    logic              block_end;
  } cmd_t;

endpackage

[rtl/brle_if.sv]
interface brle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_last;

  modport source (output valid, output data_byte, output block_last, input ready);
  modport sink   (input valid, input data_byte, input block_last, output ready);
endinterface

interface brle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       step_last;
  logic       block_end;

  modport source (output valid, output code_byte, output step_last, output block_end,
                  input ready);
  modport sink   (input valid, input code_byte, input step_last, input block_end,
                  output ready);
endinterface

[rtl/brle_front.sv]
module brle_front #(
  parameter int MAX_RUN = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  brle_in_if.sink       in_ch,
  output logic          push_valid,
  output brle_pkg::cmd_t push_cmd,
  input  logic          push_ready
);
  import brle_pkg::*;

  localparam logic [CNT_W-1:0] MaxL = CNT_W'(MAX_RUN);

  logic [BYTE_W-1:0] pend_byte_r, pend_byte_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  cmd_t              slot_r [SLOTS];
  cmd_t              slot_new [SLOTS];
  logic [SLOTS-1:0]  mask_r, mask_nxt, mask_new;

  logic              accept, ext, last;
  logic [BYTE_W-1:0] b;
  logic [CNT_W-1:0]  run_a, c1, c2, c3;
  logic              s0_app, s2_app;
  logic [SLOTS-1:0]  emits, tags;
  logic [1:0]        sel;

  assign in_ch.ready = (mask_r == '0);
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign last        = in_ch.block_last;

  // Classify the incoming byte into up to four ordered commands
  always_comb begin
    ext    = pend_vld_r && (b == pend_byte_r) && (run_r < MaxL);
    run_a  = ext ? run_r + 1'b1 : CNT_W'(1);

    // close the previous run
    mask_new[0] = !ext && pend_vld_r;
    s0_app      = (run_r < CNT_W'(2));
    slot_new[0] = '{op: s0_app ? OP_APPEND : OP_REPEAT, data: pend_byte_r, len: run_r,
                    step_last: 1'b0, block_end: 1'b0};
    c1 = (mask_new[0] && s0_app) ? cnt_r + 1'b1 : cnt_r;

    // flush the group ahead of a fresh repeat run, or when it fills
    mask_new[1] = (ext && (run_a == CNT_W'(2)) && (cnt_r != '0)) ||
                  (mask_new[0] && s0_app && (c1 == MaxL));
    slot_new[1] = '{op: OP_FLUSH, data: b, len: c1, step_last: 1'b0, block_end: 1'b0};
    c2 = mask_new[1] ? '0 : c1;

    // close the current run at the end of the block
    mask_new[2] = last;
    s2_app      = (run_a < CNT_W'(2));
    slot_new[2] = '{op: s2_app ? OP_APPEND : OP_REPEAT, data: b, len: run_a,
                    step_last: 1'b0, block_end: 1'b0};
    c3 = (last && s2_app) ? c2 + 1'b1 : c2;

    // final flush of whatever the group holds
    mask_new[3] = last && (c3 != '0);
    slot_new[3] = '{op: OP_FLUSH, data: b, len: c3, step_last: 1'b0, block_end: 1'b0};

    // mark the last command that produces output
    emits[0] = mask_new[0] && !s0_app;
    emits[1] = mask_new[1];
    emits[2] = mask_new[2] && !s2_app;
    emits[3] = mask_new[3];
    tags[3]  = emits[3];
    tags[2]  = emits[2] && !emits[3];
    tags[1]  = emits[1] && !emits[2] && !emits[3];
    tags[0]  = emits[0] && !emits[1] && !emits[2] && !emits[3];
    for (int i = 0; i < SLOTS; i++) begin
      slot_new[i].step_last = tags[i];
      slot_new[i].block_end = tags[i] && last;
    end
  end

  // Pick the lowest pending slot for the queue
  always_comb begin
    if (mask_r[0]) begin
      sel = 2'd0;
    end else if (mask_r[1]) begin
      sel = 2'd1;
    end else if (mask_r[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign push_valid = (mask_r != '0);
  assign push_cmd   = slot_r[sel];

  // Advance the run state and the slot mask
  always_comb begin
    pend_byte_nxt = pend_byte_r;
    pend_vld_nxt  = pend_vld_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    mask_nxt      = mask_r;
    if (accept) begin
      mask_nxt      = mask_new;
      pend_byte_nxt = b;
      pend_vld_nxt  = !last;
      run_nxt       = last ? '0 : run_a;
      cnt_nxt       = last ? '0 : c2;
    end else if (push_valid && push_ready) begin
      mask_nxt[sel] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_byte_r <= '0;
      pend_vld_r  <= 1'b0;
      run_r       <= '0;
      cnt_r       <= '0;
      mask_r      <= '0;
    end else begin
      pend_byte_r <= pend_byte_nxt;
      pend_vld_r  <= pend_vld_nxt;
      run_r       <= run_nxt;
      cnt_r       <= cnt_nxt;
      mask_r      <= mask_nxt;
    end
  end

  // Hold the command slots of the accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_r[i] <= slot_new[i];
      end
    end
  end

endmodule

[rtl/brle_cmdq.sv]
module brle_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  brle_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output brle_pkg::cmd_t pop_cmd,
  input  logic           pop_ready
);
  import brle_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign push_ready = (fill_r < (PTR_W+1)'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/brle_back.sv]
module brle_back #(
  parameter int MAX_RUN = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  brle_pkg::cmd_t cmd,
  output logic           cmd_ready,
  brle_out_if.source     out_ch
);
  import brle_pkg::*;

  localparam int IDX_W = $clog2(MAX_RUN);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RPT_HDR = 3'd1;
  localparam logic [2:0] ST_RPT_DAT = 3'd2;
  localparam logic [2:0] ST_FL_HDR  = 3'd3;
  localparam logic [2:0] ST_FL_DAT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0] rd_q;
  logic [BYTE_W-1:0] store [MAX_RUN];

  logic              valid_r;
  logic [BYTE_W-1:0] code_r;
  logic              sl_r, be_r;

  logic              slot_free, wr_en, emit, emit_sl, emit_be, fl_last;
  logic [BYTE_W-1:0] emit_byte;

  assign slot_free        = !valid_r || out_ch.ready;
  assign cmd_ready        = (state_r == ST_IDLE);
  assign fl_last          = (CNT_W'(idx_r) == cnt_r - 1'b1);
  assign out_ch.valid     = valid_r;
  assign out_ch.code_byte = code_r;
  assign out_ch.step_last = sl_r;
  assign out_ch.block_end = be_r;

  // Carry out one command at a time
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    wr_en     = 1'b0;
    emit      = 1'b0;
    emit_byte = '0;
    emit_sl   = 1'b0;
    emit_be   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd;
          case (cmd.op)
            OP_APPEND: begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
            OP_FLUSH: begin
              idx_nxt   = '0;
              state_nxt = ST_FL_HDR;
            end
            OP_REPEAT: begin
              state_nxt = ST_RPT_HDR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RPT_HDR: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = {2'b10, cmd_r.len};
          state_nxt = ST_RPT_DAT;
        end
      end
      ST_RPT_DAT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = cmd_r.data;
          emit_sl   = cmd_r.step_last;
          emit_be   = cmd_r.block_end;
          state_nxt = ST_IDLE;
        end
      end
      ST_FL_HDR: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = {2'b00, cnt_r};
          state_nxt = ST_FL_DAT;
        end
      end
      ST_FL_DAT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = rd_q;
          if (fl_last) begin
            emit_sl   = cmd_r.step_last;
            emit_be   = cmd_r.block_end;
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Load the command register and the output register
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (emit) begin
      code_r <= emit_byte;
      sl_r   <= emit_sl;
      be_r   <= emit_be;
    end
  end

  // Literal buffer: write on append, read the next index registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[cnt_r[IDX_W-1:0]] <= cmd.data;
    end
    rd_q <= store[idx_nxt];
  end

endmodule

[rtl/byte_run_length_encoder.sv]
// Byte run-length encoder: repeat tokens for runs, counted literal groups otherwise.
// Commands pass from the front's slot registers through the command queue to the back,
// whose output register drives the result bytes; literal appends emit no byte.
// A new input transaction is accepted only once every command (0..4) raised by the last
// one has been pushed into the command queue; output bytes leave at most one per cycle.
// Reset (rst_n low, synchronous) clears run state, command queue and output valid.
module byte_run_length_encoder #(
  parameter int MAX_RUN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  brle_in_if.sink    in_ch,
  brle_out_if.source out_ch
);
  import brle_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  brle_front #(.MAX_RUN(MAX_RUN)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  brle_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  brle_back #(.MAX_RUN(MAX_RUN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

[rtl/brle_chk.sv]
module brle_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_code_byte,
  input logic       out_step_last,
  input logic       out_block_end
);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  // The block end byte is always the last byte of its input transaction
  a_end_is_step_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_end |-> out_step_last)
    else $error("block end without step last");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

  // A stalled result transaction keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_code_byte) && $stable(out_step_last) &&
      $stable(out_block_end))
    else $error("out payload changed while stalled");

endmodule

bind byte_run_length_encoder brle_chk u_brle_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_code_byte (out_ch.code_byte),
  .out_step_last (out_ch.step_last),
  .out_block_end (out_ch.block_end)
);

[dv/byte_run_length_encoder_tb.sv]
module byte_run_length_encoder_tb;
  import brle_pkg::*;

  localparam int         MAX_RUN     = 32;
  localparam logic [7:0] REPEAT_FLAG = 8'h80;
  localparam logic [7:0] COUNT_MASK  = 8'h7F;
  localparam int         TAIL_CYCLES = 20;
  localparam int         LONG_HOLD   = 300;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              block_last;
  } raw_byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code_byte;
    logic              step_last;
    logic              block_end;
  } code_byte_t;

  logic clk;
  logic rst_n;

  brle_in_if  in_ch();
  brle_out_if out_ch();

  byte_run_length_encoder #(.MAX_RUN(MAX_RUN)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Encoder state mirrored by the predictor
  logic [BYTE_W-1:0] run_byte;
  logic              run_open;
  logic [CNT_W-1:0]  run_len;
  logic [BYTE_W-1:0] group_buf [MAX_RUN];
  logic [CNT_W-1:0]  group_cnt;

  code_byte_t step_codes[$];
  code_byte_t code_expect_q[$];
  raw_byte_t  item_q[$];
  raw_byte_t  next_item;

  int send_rate  = 0;
  int recv_rate  = 0;
  int gap_left   = 0;
  int stall_left = 0;
  int hold_req   = 0;
  int hold_seen  = 0;
  int mismatches = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor
  function automatic void emit_code(logic [BYTE_W-1:0] v);
    code_byte_t c;
    c.code_byte = v;
    c.step_last = 1'b0;
    c.block_end = 1'b0;
    step_codes.push_back(c);
  endfunction

  function automatic void flush_group();
    if (group_cnt == 0) return;
    emit_code({2'b00, group_cnt} & COUNT_MASK);
    for (int i = 0; i < group_cnt; i++) emit_code(group_buf[i]);
    group_cnt = '0;
  endfunction

  // Close the counted run: a repeat token, or one more literal
  function automatic void close_run();
    if (!run_open) return;
    if (run_len >= 2) begin
      emit_code(REPEAT_FLAG + {2'b00, run_len});
      emit_code(run_byte);
    end else begin
      if (group_cnt < MAX_RUN) begin
        group_buf[group_cnt] = run_byte;
        group_cnt++;
      end
      if (group_cnt >= MAX_RUN) flush_group();
    end
    run_open = 1'b0;
    run_len  = '0;
  endfunction

  function automatic void encode_byte(logic [BYTE_W-1:0] b, logic last);
    code_byte_t c;
    step_codes.delete();
    if (run_open && b == run_byte && run_len < MAX_RUN) begin
      run_len++;
      // pending literals go out ahead of a new repeat run
      if (run_len == 2) flush_group();
    end else begin
      close_run();
      run_byte = b;
      run_len  = CNT_W'(1);
      run_open = 1'b1;
    end
    if (last) begin
      close_run();
      flush_group();
    end
    if (step_codes.size() != 0) begin
      c = step_codes.pop_back();
      c.step_last = 1'b1;
      c.block_end = last;
      step_codes.push_back(c);
    end
    foreach (step_codes[i]) code_expect_q.push_back(step_codes[i]);
  endfunction

  // Stimulus helpers
  task automatic push_item(logic [BYTE_W-1:0] d, logic last);
    item_q.push_back(raw_byte_t'{d, last});
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 9) < 4) begin
      case ($urandom_range(0, 3))
        0: return 8'h00;
        1: return 8'hFF;
        2: return 8'h55;
        default: return 8'hAA;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_other(logic [BYTE_W-1:0] avoid);
    logic [BYTE_W-1:0] v;
    v = pick_byte();
    while (v == avoid) v = pick_byte();
    return v;
  endfunction

  // Mostly short segments, some up to and just past the cap
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 88) return $urandom_range(7, MAX_RUN - 1);
    return $urandom_range(MAX_RUN, MAX_RUN + 2);
  endfunction

  // One block: runs and literal stretches, or unstructured noise
  task automatic gen_block(inout int made);
    int         segs;
    int         len;
    logic [7:0] b;
    raw_byte_t  blk[$];
    raw_byte_t  tail;
    b = pick_byte();
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 20);
      repeat (len) blk.push_back(raw_byte_t'{8'($urandom_range(0, 255)), 1'b0});
    end else begin
      segs = $urandom_range(1, 5);
      repeat (segs) begin
        len = pick_len();
        if ($urandom_range(0, 1) == 1) begin
          b = pick_byte();
          repeat (len) blk.push_back(raw_byte_t'{b, 1'b0});
        end else begin
          repeat (len) begin
            b = pick_other(b);
            blk.push_back(raw_byte_t'{b, 1'b0});
          end
        end
      end
    end
    tail = blk.pop_back();
    tail.block_last = 1'b1;
    blk.push_back(tail);
    foreach (blk[i]) item_q.push_back(blk[i]);
    made += blk.size();
  endtask

  task automatic gen_items(int count);
    int made;
    made = 0;
    while (made < count) gen_block(made);
  endtask

  task automatic wait_drained();
    while (item_q.size() != 0 || in_ch.valid || code_expect_q.size() != 0) @(negedge clk);
  endtask

  // Driver: offer queued bytes, with random gap bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) encode_byte(in_ch.data_byte, in_ch.block_last);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (item_q.size() != 0 && send_rate != 0 &&
                     $urandom_range(0, 99) < send_rate) begin
          gap_left    <= $urandom_range(0, 14);
          in_ch.valid <= 1'b0;
        end else if (item_q.size() != 0) begin
          next_item         = item_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.data_byte  <= next_item.data_byte;
          in_ch.block_last <= next_item.block_last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Compare one output transaction with the oldest expectation
  task automatic check_code();
    code_byte_t exp_code;
    if (code_expect_q.size() == 0) begin
      $error("unexpected code_byte %02h with nothing expected", out_ch.code_byte);
      mismatches++;
      return;
    end
    exp_code = code_expect_q.pop_front();
    if (out_ch.code_byte !== exp_code.code_byte) begin
      $error("code_byte: expected %02h, actual %02h", exp_code.code_byte, out_ch.code_byte);
      mismatches++;
    end
    if (out_ch.step_last !== exp_code.step_last) begin
      $error("step_last: expected %0b, actual %0b", exp_code.step_last, out_ch.step_last);
      mismatches++;
    end
    if (out_ch.block_end !== exp_code.block_end) begin
      $error("block_end: expected %0b, actual %0b", exp_code.block_end, out_ch.block_end);
      mismatches++;
    end
  endtask

  // Monitor and receiver: check, then decide ready with stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_code();
      if (hold_seen != hold_req) begin
        hold_seen    <= hold_req;
        stall_left   <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (recv_rate != 0 && $urandom_range(0, 99) < recv_rate) begin
        stall_left   <= $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Sequence of the run
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.block_last = 1'b0;
    out_ch.ready     = 1'b0;
    run_byte         = '0;
    run_open         = 1'b0;
    run_len          = '0;
    group_cnt        = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-byte blocks at both byte extremes
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b1);
    // shortest repeat run
    push_item(8'hAA, 1'b0);
    push_item(8'hAA, 1'b1);
    // literal group flushed ahead of the run that follows it
    push_item(8'h01, 1'b0);
    push_item(8'h02, 1'b0);
    push_item(8'h03, 1'b0);
    push_item(8'h03, 1'b1);
    // run closed by a different byte, lone byte at block end
    push_item(8'h55, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item(8'h80, 1'b1);
    // literals only
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    // two runs back to back
    push_item(8'h5A, 1'b0);
    push_item(8'h5A, 1'b0);
    push_item(8'h5A, 1'b0);
    push_item(8'hA5, 1'b0);
    push_item(8'hA5, 1'b1);
    wait_drained();

    // run past the cap, then a literal stretch past the group limit
    send_rate = 15;
    recv_rate = 15;
    repeat (MAX_RUN + 1) push_item(8'hC3, 1'b0);
    for (int i = 0; i < MAX_RUN + 2; i++) push_item(8'(i * 7 + 1), 1'b0);
    push_item(8'h3C, 1'b1);
    gen_items(100);
    wait (item_q.size() == 0);

    // receiver holds off while the sender keeps offering
    @(negedge clk);
    send_rate = 0;
    recv_rate = 0;
    gen_items(60);
    hold_req++;
    wait_drained();

    send_rate = 30;
    recv_rate = 30;
    gen_items(100);
    wait_drained();

    // last part without idling; let any stall burst still running end first
    send_rate = 0;
    recv_rate = 0;
    repeat (16) @(negedge clk);
    gen_items(60);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && code_expect_q.size() == 0) begin
      $display("byte_run_length_encoder_tb: PASS");
    end else begin
      $display("byte_run_length_encoder_tb: FAIL");
    end
    $finish;
  end

  // Timeout
  initial begin
    #10_000_000;
    $display("byte_run_length_encoder_tb: FAIL");
    $finish;
  end

endmodule
